[sv/mmcs_pkg.sv]
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared constants and the command and status types that join the
// controller of the min-max column scaler to its datapath.
// ----------------------------------------------------------------------------
package mmcs_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int K_W       = 31;
	localparam int FRAC_W    = 16;
	localparam int RANGE_W   = DATA_W + 1;
	localparam int DIVD_W    = K_W + FRAC_W;
	localparam int PROD_W    = 2 * DATA_W;

	localparam logic [K_W-1:0] K_RESET = K_W'(65536);
	localparam logic [K_W-1:0] K_MAX   = {K_W{1'b1}};

	typedef struct packed {
		logic load;
		logic div_start;
		logic scale_ld;
		logic offs_prod;
		logic offs_ld;
		logic rd;
		logic mul;
		logic out_load;
		logic idx_inc;
		logic col_clr;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
		logic last;
	} stat_t;

endpackage

[sv/mmcs_divider.sv]
// ----------------------------------------------------------------------------
// mmcs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmcs_divider #(
	parameter int N_W = mmcs_pkg::DIVD_W,
	parameter int D_W = mmcs_pkg::RANGE_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dsr_q;
	logic [N_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[N_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= D_W'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[D_W-1:0];
			end
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/mmcs_datapath.sv]
// ----------------------------------------------------------------------------
// mmcs_datapath
// Sample store, running minimum and maximum, scale and offset arithmetic,
// per-sample scaling and the output register.
// ----------------------------------------------------------------------------
module mmcs_datapath #(
	parameter int DEPTH = mmcs_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mmcs_pkg::K_W-1:0]    cfg_wr_data,
	input  logic signed [mmcs_pkg::DATA_W-1:0] sample,
	input  mmcs_pkg::cmd_t              cmd,
	output mmcs_pkg::stat_t             stat,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [mmcs_pkg::K_W-1:0]    scaled_value,
	output logic [mmcs_pkg::K_W-1:0]    scale_factor,
	output logic signed [mmcs_pkg::DATA_W-1:0] offset_term,
	output logic                        flat_column,
	output logic                        overflowed,
	output logic                        end_of_run
);

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int DATA_W  = mmcs_pkg::DATA_W;
	localparam int K_W     = mmcs_pkg::K_W;
	localparam int FRAC_W  = mmcs_pkg::FRAC_W;
	localparam int RANGE_W = mmcs_pkg::RANGE_W;
	localparam int DIVD_W  = mmcs_pkg::DIVD_W;
	localparam int PROD_W  = mmcs_pkg::PROD_W;
	localparam int Y_W     = PROD_W - FRAC_W;

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [K_W-1:0]           target_range_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic [CW-1:0]            count_q;
	logic                     ovf_q;
	logic [AW-1:0]            idx_q;
	logic signed [DATA_W-1:0] rd_data_q;
	logic [K_W-1:0]           scale_q;
	logic                     flat_q;
	logic signed [PROD_W-1:0] oprod_q;
	logic signed [DATA_W-1:0] offs_q;
	logic [PROD_W-1:0]        prod_q;

	logic                     out_valid_q;
	logic [K_W-1:0]           scaled_q;
	logic [K_W-1:0]           scale_out_q;
	logic signed [DATA_W-1:0] offs_out_q;
	logic                     flat_out_q;
	logic                     ovf_out_q;
	logic                     eor_q;

	logic                     has_room;
	logic [RANGE_W-1:0]       range;
	logic                     div_done;
	logic [DIVD_W-1:0]        quotient;
	logic [K_W-1:0]           scale_sat;
	logic signed [PROD_W-1:0] oneg;
	logic signed [PROD_W-1:0] osh;
	logic signed [DATA_W-1:0] offs_sat;
	logic [RANGE_W-1:0]       diff;
	logic [Y_W-1:0]           y_full;
	logic [K_W-1:0]           y_clamp;
	logic                     last;
	logic                     out_free;

	assign has_room = count_q < CW'(DEPTH);
	assign range    = RANGE_W'({max_q[DATA_W-1], max_q} - {min_q[DATA_W-1], min_q});

	mmcs_divider #(
		.N_W(DIVD_W),
		.D_W(RANGE_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend({target_range_q, {FRAC_W{1'b0}}}),
		.divisor (range),
		.done    (div_done),
		.quotient(quotient)
	);

	always_comb begin
		if (|quotient[DIVD_W-1:K_W]) begin
			scale_sat = mmcs_pkg::K_MAX;
		end else begin
			scale_sat = quotient[K_W-1:0];
		end
	end

	always_comb begin
		oneg = -oprod_q;
		osh  = oneg >>> FRAC_W;
		if (osh[PROD_W-1:DATA_W-1] == '0 || osh[PROD_W-1:DATA_W-1] == '1) begin
			offs_sat = osh[DATA_W-1:0];
		end else if (osh[PROD_W-1]) begin
			offs_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			offs_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	assign diff   = RANGE_W'({rd_data_q[DATA_W-1], rd_data_q} - {min_q[DATA_W-1], min_q});
	assign y_full = prod_q[PROD_W-1:FRAC_W];

	always_comb begin
		if (y_full > Y_W'(target_range_q)) begin
			y_clamp = target_range_q;
		end else begin
			y_clamp = y_full[K_W-1:0];
		end
	end

	assign last     = (CW'(idx_q) + CW'(1)) == count_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_range_q <= mmcs_pkg::K_RESET;
		end else if (cfg_wr_en) begin
			target_range_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.col_clr) begin
			min_q   <= '0;
			max_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (has_room) begin
				count_q <= count_q + CW'(1);
				if (count_q == '0) begin
					min_q <= sample;
					max_q <= sample;
				end else begin
					if (sample < min_q) begin
						min_q <= sample;
					end
					if (sample > max_q) begin
						max_q <= sample;
					end
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[count_q[AW-1:0]] <= sample;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale_ld) begin
			flat_q  <= (range == '0);
			scale_q <= (range == '0) ? '0 : scale_sat;
		end
		if (cmd.offs_prod) begin
			oprod_q <= PROD_W'($signed({1'b0, scale_q})) * PROD_W'(min_q);
		end
		if (cmd.offs_ld) begin
			offs_q <= offs_sat;
		end
		if (cmd.offs_ld) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(scale_q) * PROD_W'(diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			scaled_q    <= y_clamp;
			scale_out_q <= scale_q;
			offs_out_q  <= offs_q;
			flat_out_q  <= flat_q;
			ovf_out_q   <= ovf_q;
			eor_q       <= last;
		end
	end

	assign stat.div_done = div_done;
	assign stat.out_free = out_free;
	assign stat.last     = last;

	assign out_valid    = out_valid_q;
	assign scaled_value = scaled_q;
	assign scale_factor = scale_out_q;
	assign offset_term  = offs_out_q;
	assign flat_column  = flat_out_q;
	assign overflowed   = ovf_out_q;
	assign end_of_run   = eor_q;

endmodule

[sv/mmcs_ctrl.sv]
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Sequencer of the min-max column scaler: sample loading, division, offset
// computation and emission of the scaled column.
// ----------------------------------------------------------------------------
module mmcs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            is_final,
	output logic            in_stall,
	output mmcs_pkg::cmd_t  cmd,
	input  mmcs_pkg::stat_t stat
);

	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_DIVGO = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_SCALE = 9'b000001000,
		ST_PROD  = 9'b000010000,
		ST_OFFS  = 9'b000100000,
		ST_RD    = 9'b001000000,
		ST_MUL   = 9'b010000000,
		ST_PUT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (is_final) begin
						state_nxt = ST_DIVGO;
					end
				end
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_nxt = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale_ld = 1'b1;
				state_nxt    = ST_PROD;
			end
			ST_PROD: begin
				cmd.offs_prod = 1'b1;
				state_nxt     = ST_OFFS;
			end
			ST_OFFS: begin
				cmd.offs_ld = 1'b1;
				state_nxt   = ST_RD;
			end
			ST_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_PUT;
			end
			ST_PUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.last) begin
						cmd.col_clr = 1'b1;
						state_nxt   = ST_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt   = ST_RD;
					end
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

endmodule

[sv/min_max_column_scaler.sv]
// ----------------------------------------------------------------------------
// min_max_column_scaler
// Min-max normalization of one column of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Samples enter on the request channel (in_valid, in_stall, sample,
// is_final); each one is buffered, up to DEPTH per column, while the
// running minimum and maximum are tracked. Further samples are dropped and
// reported through overflowed.
// After the final sample the block stalls its input, divides k by the
// column range in a bit-serial divider, and forms the offset. It then sends
// one request per buffered sample on the result channel, each through the
// store read, the multiplier and the output register.
// The output register holds a result while out_stall is high; the sequencer
// waits for it to drain before loading the next one. After the last result
// is loaded, new samples are accepted at once.
// Reset returns target_range to 1.0 and empties the column; the sample
// store is not cleared. The user must see that target_range is written
// with cfg_wr_en only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module min_max_column_scaler #(
	parameter int DEPTH = mmcs_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mmcs_pkg::K_W-1:0]           cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [mmcs_pkg::DATA_W-1:0] sample,
	input  logic                               is_final,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mmcs_pkg::K_W-1:0]           scaled_value,
	output logic [mmcs_pkg::K_W-1:0]           scale_factor,
	output logic signed [mmcs_pkg::DATA_W-1:0] offset_term,
	output logic                               flat_column,
	output logic                               overflowed,
	output logic                               end_of_run
);

	mmcs_pkg::cmd_t  cmd;
	mmcs_pkg::stat_t stat;

	mmcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.is_final(is_final),
		.in_stall(in_stall),
		.cmd     (cmd),
		.stat    (stat)
	);

	mmcs_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (sample),
		.cmd         (cmd),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.scaled_value(scaled_value),
		.scale_factor(scale_factor),
		.offset_term (offset_term),
		.flat_column (flat_column),
		.overflowed  (overflowed),
		.end_of_run  (end_of_run)
	);

endmodule
